/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions on the UTF-8 decoder ports.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define U8D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int CP_W  = 21;
	localparam int LEN_W = 3;

	// Payload masks for leading and continuation bytes.
	localparam logic [7:0] LEAD2_MASK = 8'h1f;
	localparam logic [7:0] LEAD3_MASK = 8'h0f;
	localparam logic [7:0] LEAD4_MASK = 8'h07;
	localparam logic [7:0] CONT_MASK  = 8'h3f;
	localparam logic [7:0] TAG_MASK   = 8'hc0;
	localparam logic [7:0] CONT_TAG   = 8'h80;

	// Leading byte range limits.
	localparam logic [7:0] ASCII_END  = 8'h7f;
	localparam logic [7:0] LEAD2_LO   = 8'hc2;
	localparam logic [7:0] LEAD2_HI   = 8'hdf;
	localparam logic [7:0] LEAD3_LO   = 8'he0;
	localparam logic [7:0] LEAD3_HI   = 8'hef;
	localparam logic [7:0] LEAD4_LO   = 8'hf0;
	localparam logic [7:0] LEAD4_HI   = 8'hf4;

	// Surrogate range.
	localparam logic [CP_W-1:0] SURR_LO = 21'h00d800;
	localparam logic [CP_W-1:0] SURR_HI = 21'h00dfff;

	// Sequence lengths.
	localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
	localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
	localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
	localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

	// Pending sequence held between bytes.
	typedef struct packed {
		logic [1:0]       bytes_remaining;
		logic [CP_W-1:0]  partial_value;
		logic [LEN_W-1:0] pending_length;
	} dec_state_t;

	// One decoded result beat.
	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic             valid_res;
		logic [LEN_W-1:0] sequence_length;
	} dec_result_t;

	// What the decode step hands back for one byte.
	typedef struct packed {
		logic        emit;
		dec_result_t result;
	} dec_out_t;

endpackage

/* rtl/core/u8d_in_if.sv */
// ----------------------------------------------------------------------------
// u8d_in_if
// Byte stream channel: one raw byte and a last-byte flag per beat.
// ----------------------------------------------------------------------------
interface u8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/core/u8d_out_if.sv */
// ----------------------------------------------------------------------------
// u8d_out_if
// Decoded code point channel: one result per beat.
// ----------------------------------------------------------------------------
interface u8d_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        valid_res;
	logic [2:0]  sequence_length;

	modport source (output valid, output code_point, output valid_res,
		output sequence_length, input ready);
	modport sink (input valid, input code_point, input valid_res,
		input sequence_length, output ready);
endinterface

/* rtl/core/u8d_decode.sv */
// ----------------------------------------------------------------------------
// u8d_decode
// One decode step: pending sequence plus one byte gives the next pending
// sequence and at most one result.
// ----------------------------------------------------------------------------
module u8d_decode import u8d_pkg::*; (
	input  dec_state_t state,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output dec_state_t next_state,
	output dec_out_t   dec
);

	localparam dec_state_t IDLE = '0;

	logic [CP_W-1:0] shifted;
	logic [1:0]      rem_dec;

	// Partial value with the new continuation payload appended.
	assign shifted = {state.partial_value[CP_W-7:0], data_byte[5:0] & CONT_MASK[5:0]};
	assign rem_dec = state.bytes_remaining - 2'd1;

	always_comb begin
		next_state = state;
		dec.emit   = 1'b0;
		dec.result = '0;

		if (state.bytes_remaining == 2'd0) begin
			// Idle: classify the leading byte.
			priority if (data_byte <= ASCII_END) begin
				dec.emit = 1'b1;
				dec.result.code_point = {13'd0, data_byte};
				dec.result.valid_res = 1'b1;
				dec.result.sequence_length = LEN_ONE;
			end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI && !last_byte) begin
				next_state.bytes_remaining = 2'd1;
				next_state.pending_length = LEN_TWO;
				next_state.partial_value = {13'd0, data_byte & LEAD2_MASK};
			end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI && !last_byte) begin
				next_state.bytes_remaining = 2'd2;
				next_state.pending_length = LEN_THREE;
				next_state.partial_value = {13'd0, data_byte & LEAD3_MASK};
			end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI && !last_byte) begin
				next_state.bytes_remaining = 2'd3;
				next_state.pending_length = LEN_FOUR;
				next_state.partial_value = {13'd0, data_byte & LEAD4_MASK};
			end else begin
				// Bad leading byte, or a multi-byte lead cut off by the last flag.
				next_state = IDLE;
				dec.emit = 1'b1;
			end
		end else begin
			// A sequence is open: expect a continuation byte.
			priority if ((data_byte & TAG_MASK) != CONT_TAG) begin
				next_state = IDLE;
				dec.emit = 1'b1;
			end else if (rem_dec == 2'd0) begin
				next_state = IDLE;
				dec.emit = 1'b1;
				if (!(shifted >= SURR_LO && shifted <= SURR_HI)) begin
					dec.result.code_point = shifted;
					dec.result.valid_res = 1'b1;
					dec.result.sequence_length = state.pending_length;
				end
			end else if (last_byte) begin
				// Sequence truncated at the end of the buffer.
				next_state = IDLE;
				dec.emit = 1'b1;
			end else begin
				next_state.bytes_remaining = rem_dec;
				next_state.partial_value = shifted;
			end
		end
	end

endmodule

/* rtl/core/utf8_stream_decoder.sv */
// Bytes wait in the input register; result beats leave from the result register.
// Throughput: one byte per cycle unless results stall; state_q closes the only loop.
// Bytes that open or extend a sequence give no result beat.
// Reset clears the pending sequence to idle and empties both register stages.
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder with an input register, one decode step and a
// result register; stalls on the result side back up through the input stage.
// ----------------------------------------------------------------------------
module utf8_stream_decoder import u8d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	u8d_in_if.sink      raw,
	u8d_out_if.source   decoded
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	dec_state_t  state_q;
	dec_state_t  state_next;
	dec_out_t    dec;
	logic        out_valid_q;
	dec_result_t result_q;
	logic        out_free;
	logic        s1_take;

	u8d_decode u_decode (
		.state      (state_q),
		.data_byte  (byte_s1),
		.last_byte  (last_s1),
		.next_state (state_next),
		.dec        (dec)
	);

	// Handshake: the staged byte moves on unless it needs a full result slot.
	assign out_free  = !out_valid_q || decoded.ready;
	assign s1_take   = valid_s1 && (!dec.emit || out_free);
	assign raw.ready = !valid_s1 || s1_take;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (raw.ready) begin
			valid_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.ready && raw.valid) begin
			byte_s1 <= raw.data_byte;
			last_s1 <= raw.last_byte;
		end
	end

	// Pending sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_take) begin
			state_q <= state_next;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_take && dec.emit) begin
			out_valid_q <= 1'b1;
		end else if (decoded.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && dec.emit) begin
			result_q <= dec.result;
		end
	end

	assign decoded.valid           = out_valid_q;
	assign decoded.code_point      = result_q.code_point;
	assign decoded.valid_res       = result_q.valid_res;
	assign decoded.sequence_length = result_q.sequence_length;

endmodule

/* rtl/core/u8d_checker.sv */
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks on the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [20:0] code_point,
	input logic        valid_res,
	input logic [2:0]  sequence_length
);

	// A stalled result beat keeps its payload.
	`U8D_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, $stable({code_point, valid_res, sequence_length}), "result beat changed while stalled")

	// Error beats carry no code point and no length.
	`U8D_ASSERT_NOW(a_err_zero, clk, arst_n, out_valid && !valid_res, code_point == 21'd0 && sequence_length == 3'd0, "error beat with nonzero payload")

	// Good beats carry a length of one to four, and one-byte beats are ASCII.
	`U8D_ASSERT_NOW(a_ok_len, clk, arst_n, out_valid && valid_res, (sequence_length == 3'd1 && code_point[20:7] == 14'd0) || sequence_length == 3'd2 || sequence_length == 3'd3 || sequence_length == 3'd4, "good beat with bad length")

	// A fresh result beat follows a byte accepted by the input register.
	`U8D_ASSERT_NOW(a_rise_src, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result beat without a source byte")

endmodule

bind utf8_stream_decoder u8d_checker u_u8d_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (raw.valid),
	.in_ready        (raw.ready),
	.out_valid       (decoded.valid),
	.out_ready       (decoded.ready),
	.code_point      (decoded.code_point),
	.valid_res       (decoded.valid_res),
	.sequence_length (decoded.sequence_length)
);

/* verif/utf8_stream_decoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_test
// Self-checking bench for the byte-serial UTF-8 decoder. A scoreboard keeps
// its own copy of the pending sequence, predicts any result beat for every
// accepted byte and compares each decoded beat in order. Stimulus is a short
// directed set of edge cases followed by mostly well-formed random sequences
// with noise, truncations and broken continuations mixed in. Both sides
// stall at random.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_test;
	import u8d_pkg::*;

	// Scoreboard: predicts result beats from accepted bytes and checks them.
	class utf8_scoreboard;
		logic [1:0]       cont_left;
		logic [CP_W-1:0]  acc_value;
		logic [LEN_W-1:0] open_len;
		dec_result_t      expected_q[$];
		int unsigned      fails;
		int unsigned      good_seen;
		int unsigned      bad_seen;

		function new();
			cont_left = '0;
			acc_value = '0;
			open_len  = LEN_NONE;
			fails     = 0;
			good_seen = 0;
			bad_seen  = 0;
		endfunction

		function void go_idle();
			cont_left = '0;
			acc_value = '0;
			open_len  = LEN_NONE;
		endfunction

		function void push_fault();
			dec_result_t r;
			go_idle();
			r.code_point      = '0;
			r.valid_res       = 1'b0;
			r.sequence_length = LEN_NONE;
			expected_q.push_back(r);
		endfunction

		function void push_good(logic [CP_W-1:0] cp, logic [LEN_W-1:0] len);
			dec_result_t r;
			r.code_point      = cp;
			r.valid_res       = 1'b1;
			r.sequence_length = len;
			expected_q.push_back(r);
		endfunction

		// Note one accepted byte and queue the result it causes, if any.
		function void note_byte(logic [7:0] b, logic lst);
			logic [LEN_W-1:0] len;
			logic [7:0]       lead;
			if (cont_left == 2'd0) begin
				if (b <= ASCII_END) begin
					push_good({13'd0, b}, LEN_ONE);
					return;
				end
				if (b >= LEAD2_LO && b <= LEAD2_HI) begin
					len  = LEN_TWO;
					lead = b & LEAD2_MASK;
				end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
					len  = LEN_THREE;
					lead = b & LEAD3_MASK;
				end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
					len  = LEN_FOUR;
					lead = b & LEAD4_MASK;
				end else begin
					push_fault();
					return;
				end
				if (lst) begin
					push_fault();
					return;
				end
				cont_left = 2'(len - 1);
				open_len  = len;
				acc_value = {13'd0, lead};
				return;
			end

			// A sequence is open: only a continuation byte may follow.
			if ((b & TAG_MASK) != CONT_TAG) begin
				push_fault();
				return;
			end
			acc_value = CP_W'({acc_value, b[5:0]});
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				if (acc_value >= SURR_LO && acc_value <= SURR_HI) begin
					push_fault();
				end else begin
					push_good(acc_value, open_len);
					go_idle();
				end
			end else if (lst) begin
				push_fault();
			end
		endfunction

		// Compare one decoded beat with the oldest prediction.
		function void check_result(dec_result_t got);
			dec_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected beat cp=%h ok=%b len=%0d", $time,
					got.code_point, got.valid_res, got.sequence_length);
				fails++;
				return;
			end
			want = expected_q.pop_front();
			if (got.valid_res === 1'b1)
				good_seen++;
			else
				bad_seen++;
			if (got.code_point !== want.code_point) begin
				$display("%0t: code_point expected %h actual %h", $time,
					want.code_point, got.code_point);
				fails++;
			end
			if (got.valid_res !== want.valid_res) begin
				$display("%0t: valid_res expected %b actual %b", $time,
					want.valid_res, got.valid_res);
				fails++;
			end
			if (got.sequence_length !== want.sequence_length) begin
				$display("%0t: sequence_length expected %0d actual %0d", $time,
					want.sequence_length, got.sequence_length);
				fails++;
			end
		endfunction
	endclass

	localparam int BYTE_TARGET  = 1450;
	localparam int CALM_FROM    = 1250;
	localparam int HOLD_CYCLES  = 64;
	localparam int SETTLE_CYCLES = 6;

	logic clk;
	logic arst_n;

	u8d_in_if  raw_ch ();
	u8d_out_if dec_ch ();

	utf8_stream_decoder uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.raw     (raw_ch),
		.decoded (dec_ch)
	);

	utf8_scoreboard sb = new();

	int unsigned sent_bytes = 0;
	int unsigned drains     = 0;
	bit          calm       = 1'b0;
	bit          hold_req   = 1'b0;
	bit          hold_active = 1'b0;
	bit          hold_done  = 1'b0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall time limit.
	initial begin
		#5000000;
		$display("utf8_stream_decoder: mismatch");
		$finish;
	end

	// Check every decoded beat taken at a clock edge.
	always @(posedge clk) begin
		if (arst_n && dec_ch.valid && dec_ch.ready)
			sb.check_result('{dec_ch.code_point, dec_ch.valid_res,
				dec_ch.sequence_length});
	end

	// Output side: random stall bursts, one long hold-off on request.
	initial begin
		dec_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_active = 1'b1;
				dec_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
				hold_req    = 1'b0;
				hold_done   = 1'b1;
			end else if (calm) begin
				dec_ch.ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				dec_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				dec_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Offer one byte and wait until the decoder takes it.
	task automatic drive_byte(input logic [7:0] b, input logic lst);
		raw_ch.valid     <= 1'b1;
		raw_ch.data_byte <= b;
		raw_ch.last_byte <= lst;
		do @(posedge clk); while (!raw_ch.ready);
		sb.note_byte(b, lst);
		sent_bytes++;
	endtask

	// Same as drive_byte, but sometimes preceded by an idle burst.
	task automatic offer_byte(input logic [7:0] b, input logic lst);
		if (!calm && $urandom_range(0, 7) == 0) begin
			raw_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		drive_byte(b, lst);
	endtask

	// Stop sending until every predicted beat has come back.
	task automatic drain_results();
		raw_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.expected_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		drains++;
	endtask

	// Keep offering bytes while the output side holds off, so the
	// decoder fills up and stalls its input.
	task automatic flood_while_held();
		int i;
		raw_ch.valid <= 1'b0;
		hold_req = 1'b1;
		do @(posedge clk); while (!hold_active);
		for (i = 0; i < 48; i++)
			drive_byte(8'($urandom_range(0, ASCII_END)), 1'($urandom_range(0, 1)));
	endtask

	function automatic logic [7:0] cont_byte();
		return CONT_TAG | 8'($urandom_range(0, 63));
	endfunction

	// One random sequence: mostly well-formed with random payload, the rest
	// noise, bad leads, broken continuations and cut-off sequences.
	task automatic send_sequence();
		logic [7:0] seq_bytes [4];
		logic       seq_last  [4];
		int         kind;
		int         n;
		int         i;
		int         pos;
		int         r;
		kind = $urandom_range(0, 99);
		n = 1;
		for (i = 0; i < 4; i++) begin
			seq_bytes[i] = cont_byte();
			seq_last[i]  = 1'b0;
		end
		if (kind < 20 || kind >= 78) begin
			n = 1;
			seq_bytes[0] = 8'($urandom_range(0, ASCII_END));
		end
		if (kind >= 20 && kind < 40 || kind >= 92) begin
			n = 2;
			seq_bytes[0] = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
		end
		if (kind >= 40 && kind < 60 || kind >= 94) begin
			n = 3;
			seq_bytes[0] = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
			// Lead ED reaches the surrogate range half the time.
			if ($urandom_range(0, 3) == 0)
				seq_bytes[0] = 8'hed;
		end
		if (kind >= 60 && kind < 78 || kind >= 97) begin
			n = 4;
			seq_bytes[0] = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
		end
		seq_last[n-1] = ($urandom_range(0, 5) == 0);

		if (kind >= 78 && kind < 86) begin
			// Raw noise byte.
			seq_bytes[0] = 8'($urandom_range(0, 255));
		end else if (kind >= 86 && kind < 92) begin
			// Leading byte that no sequence may start with.
			r = $urandom_range(0, 76);
			seq_bytes[0] = (r < 66) ? 8'(8'h80 + r) : 8'(8'hf5 + r - 66);
		end else if (kind >= 92 && kind < 96 && n > 1) begin
			// Continuation byte whose top bits are not 10.
			r = $urandom_range(0, 191);
			pos = $urandom_range(1, n - 1);
			seq_bytes[pos] = (r >= 128) ? 8'(r + 64) : 8'(r);
			n = pos + 1;
		end else if (kind >= 96 && n > 1) begin
			// Buffer ends before the sequence is complete.
			pos = $urandom_range(0, n - 2);
			seq_last[pos] = 1'b1;
			n = pos + 1;
		end

		for (i = 0; i < n; i++)
			offer_byte(seq_bytes[i], seq_last[i]);
	endtask

	// Reset and stimulus.
	initial begin
		arst_n           = 1'b0;
		raw_ch.valid     = 1'b0;
		raw_ch.data_byte = '0;
		raw_ch.last_byte = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single-byte extremes, with and without the last flag.
		offer_byte(8'h00, 1'b0);
		offer_byte(ASCII_END, 1'b1);
		// Two-byte extremes; last flag on a completing byte is fine.
		offer_byte(LEAD2_LO, 1'b0);
		offer_byte(8'hbf, 1'b1);
		offer_byte(LEAD2_HI, 1'b0);
		offer_byte(CONT_TAG, 1'b0);
		// Overlong three-byte form is accepted.
		offer_byte(LEAD3_LO, 1'b0);
		offer_byte(CONT_TAG, 1'b0);
		offer_byte(CONT_TAG, 1'b0);
		// Surrogate D800.
		offer_byte(8'hed, 1'b0);
		offer_byte(8'ha0, 1'b0);
		offer_byte(CONT_TAG, 1'b0);
		// Largest four-byte value.
		offer_byte(LEAD4_HI, 1'b0);
		offer_byte(8'hbf, 1'b0);
		offer_byte(8'hbf, 1'b0);
		offer_byte(8'hbf, 1'b1);
		// Bad leading bytes at both ends of both forbidden ranges.
		offer_byte(8'h80, 1'b0);
		offer_byte(8'hc1, 1'b0);
		offer_byte(8'hf5, 1'b0);
		offer_byte(8'hff, 1'b0);
		// Bad continuation: the ASCII byte is swallowed by the error.
		offer_byte(8'hc3, 1'b0);
		offer_byte(8'h41, 1'b0);
		// Truncation on the leading byte and on a middle continuation.
		offer_byte(8'he2, 1'b1);
		offer_byte(8'he2, 1'b0);
		offer_byte(8'h82, 1'b1);

		// Random sequences with a long output stall and a full drain inside.
		while (sent_bytes < BYTE_TARGET) begin
			if (!hold_done && !hold_req && sent_bytes >= 500)
				flood_while_held();
			if (drains == 0 && sent_bytes >= 900)
				drain_results();
			if (sent_bytes >= CALM_FROM)
				calm = 1'b1;
			send_sequence();
		end

		drain_results();
		$display("Decoded %0d bytes into %0d good and %0d error beats.",
			sent_bytes, sb.good_seen, sb.bad_seen);
		$display("Covered edge cases, random stalls, one long output hold-off and drains.");
		if (sb.fails == 0 && sb.expected_q.size() == 0) begin
			$display("utf8_stream_decoder: match");
		end else begin
			$display("utf8_stream_decoder: mismatch");
		end
		$finish;
	end

endmodule
